// ----- sv/lse_pkg.sv -----
// Shared types, codes and helper functions for the LSB embed/extract block.
package lse_pkg;

    // Fixed field and state widths.
    localparam int BYTE_BITS            = 8;
    localparam int BUF_WIDTH            = 15;
    localparam int FILL_WIDTH           = 4;
    localparam int COUNT_WIDTH          = 16;
    localparam int STATUS_WIDTH         = 3;
    localparam int OPCODE_WIDTH         = 2;
    localparam int CFG_INDEX_WIDTH      = 2;
    localparam int BPB_WIDTH            = 4;
    localparam int DEFAULT_LENGTH_WIDTH = 16;

    // Input opcodes.
    localparam logic [OPCODE_WIDTH-1:0] OP_MESSAGE  = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_CARRIER  = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR    = 2'd2;
    localparam logic [OPCODE_WIDTH-1:0] OP_RESERVED = 2'd3;

    // Result status codes.
    localparam logic [STATUS_WIDTH-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_REFUSED = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_PADDED  = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_DONE    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BITS_PER_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXTRACT_MODE   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MESSAGE_LENGTH = 2'd2;

    // Reset value of bits_per_byte.
    localparam logic [BPB_WIDTH-1:0] BPB_RESET = 4'd1;

    // One input beat.
    typedef struct packed {
        logic [OPCODE_WIDTH-1:0] opcode;
        logic [BYTE_BITS-1:0]    data_byte;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [BYTE_BITS-1:0]    out_byte;
        logic                    out_valid;
        logic [STATUS_WIDTH-1:0] status;
    } out_item_t;

    // Mode settings that steer the datapath.
    typedef struct packed {
        logic [BPB_WIDTH-1:0] bits_per_byte;
        logic                 extract_mode;
    } cfg_ctrl_t;

    // Bit buffer and counters carried from one beat to the next.
    typedef struct packed {
        logic [BUF_WIDTH-1:0]   bit_buffer;
        logic [FILL_WIDTH-1:0]  buffered_bits;
        logic [COUNT_WIDTH-1:0] byte_counter;
    } stream_state_t;

    // Mask of the low k bits of the bit buffer.
    function automatic logic [BUF_WIDTH-1:0] low_mask(input logic [FILL_WIDTH-1:0] k);
        logic [BUF_WIDTH:0] ones;
        ones = ({{BUF_WIDTH{1'b0}}, 1'b1} << k) - {{BUF_WIDTH{1'b0}}, 1'b1};
        return ones[BUF_WIDTH-1:0];
    endfunction

    // Bits per carrier byte as used: zero counts as one, above eight as eight.
    function automatic logic [FILL_WIDTH-1:0] eff_n(input logic [BPB_WIDTH-1:0] bpb);
        logic [FILL_WIDTH-1:0] n;
        if (bpb == '0)
        begin
            n = FILL_WIDTH'(1);
        end
        else if (bpb > BPB_WIDTH'(BYTE_BITS))
        begin
            n = FILL_WIDTH'(BYTE_BITS);
        end
        else
        begin
            n = bpb;
        end
        return n;
    endfunction

endpackage

// ----- sv/lsb_stego_embed_extract_top.sv -----
// Top level of the LSB embed/extract block: beat registers, stream state and checks.
//
// Hides message bytes in the low n bits of carrier bytes, or recovers them, with n
// set by bits_per_byte from one to eight. Every input beat, whatever its opcode,
// gives exactly one result beat. The block takes one beat per clock cycle unless
// out_ready holds it back, and returns each result through the input register,
// then the shift, mask and merge of the datapath into the result register. The
// bit buffer and counters are updated as a beat leaves the input register, so a
// new beat may follow on every cycle. Ready falls only when both registers are
// full and out_ready is low. Configuration writes restart the stream and must
// be made only while no beat is in flight.
module lsb_stego_embed_extract_top #(
    parameter int LENGTH_WIDTH = lse_pkg::DEFAULT_LENGTH_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lse_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lse_pkg::out_item_t                  out_item,
    input  logic                                cfg_we,
    input  logic [lse_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [LENGTH_WIDTH-1:0]             cfg_data
);
    import lse_pkg::*;

    localparam int LEFT_WIDTH = LENGTH_WIDTH + 3;

    cfg_ctrl_t               ctrl;
    logic [LENGTH_WIDTH-1:0] message_length;
    logic                    cfg_clear;
    logic [LENGTH_WIDTH-1:0] reload_length;

    in_item_t                in_item_reg;
    logic                    in_full_reg;
    out_item_t               out_item_reg;
    logic                    out_full_reg;
    logic                    advance;

    stream_state_t           state_reg;
    stream_state_t           state_next;
    stream_state_t           step_state;
    logic [LEFT_WIDTH-1:0]   bits_left_reg;
    logic [LEFT_WIDTH-1:0]   bits_left_next;
    logic [LEFT_WIDTH-1:0]   step_bits_left;
    out_item_t               step_result;

    // Configuration registers.
    lse_cfg #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ctrl          (ctrl),
        .message_length(message_length),
        .clear         (cfg_clear),
        .reload_length (reload_length)
    );

    // Datapath for the beat held in the input register.
    lse_step #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_step (
        .item          (in_item_reg),
        .ctrl          (ctrl),
        .message_length(message_length),
        .cur           (state_reg),
        .bits_left     (bits_left_reg),
        .nxt           (step_state),
        .bits_left_next(step_bits_left),
        .result        (step_result)
    );

    // A beat moves on when the result register is empty or being drained.
    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    // Input beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    // Result beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_full_reg;
    assign out_item  = out_item_reg;

    // Stream state: a configuration write restarts it, a beat updates it.
    always_comb
    begin
        state_next     = state_reg;
        bits_left_next = bits_left_reg;
        if (cfg_clear)
        begin
            state_next     = '0;
            bits_left_next = {reload_length, 3'b000};
        end
        else if (advance)
        begin
            state_next     = step_state;
            bits_left_next = step_bits_left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            bits_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
        end
    end

`ifndef SYNTH
    // Buffer bits above the fill level are always zero.
    a_buffer_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bit_buffer & ~low_mask(state_reg.buffered_bits)) == '0)
        else $error("bit buffer holds bits above its fill level");

    // In extract mode a complete byte never stays in the buffer.
    a_extract_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctrl.extract_mode) |=> (state_reg.buffered_bits < FILL_WIDTH'(BYTE_BITS)))
        else $error("extract left eight or more bits buffered");

    // Every beat that leaves the input register lands in the result register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_full_reg)
        else $error("result beat lost");

    // A result without a meaningful byte carries a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !out_item_reg.out_valid) |-> (out_item_reg.out_byte == '0))
        else $error("non-meaningful result carries a nonzero byte");
`endif

endmodule

// ----- sv/lse_cfg.sv -----
// Configuration registers of the LSB embed/extract block.
module lse_cfg #(
    parameter int LENGTH_WIDTH = lse_pkg::DEFAULT_LENGTH_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lse_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [LENGTH_WIDTH-1:0]              cfg_data,
    output lse_pkg::cfg_ctrl_t                   ctrl,
    output logic [LENGTH_WIDTH-1:0]              message_length,
    output logic                                 clear,
    output logic [LENGTH_WIDTH-1:0]              reload_length
);
    import lse_pkg::*;

    cfg_ctrl_t               ctrl_reg;
    cfg_ctrl_t               ctrl_next;
    logic [LENGTH_WIDTH-1:0] length_reg;
    logic [LENGTH_WIDTH-1:0] length_next;
    logic                    hit;

    // Decode a write; an unknown index changes nothing.
    always_comb
    begin
        ctrl_next   = ctrl_reg;
        length_next = length_reg;
        hit         = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BITS_PER_BYTE:
                begin
                    ctrl_next.bits_per_byte = cfg_data[BPB_WIDTH-1:0];
                    hit = 1'b1;
                end
                REG_EXTRACT_MODE:
                begin
                    ctrl_next.extract_mode = cfg_data[0];
                    hit = 1'b1;
                end
                REG_MESSAGE_LENGTH:
                begin
                    length_next = cfg_data;
                    hit = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.bits_per_byte <= BPB_RESET;
            ctrl_reg.extract_mode  <= 1'b0;
            length_reg             <= '0;
        end
        else
        begin
            ctrl_reg   <= ctrl_next;
            length_reg <= length_next;
        end
    end

    // Any accepted write restarts the stream with the new length.
    assign ctrl           = ctrl_reg;
    assign message_length = length_reg;
    assign clear          = hit;
    assign reload_length  = length_next;

endmodule

// ----- sv/lse_step.sv -----
// Single-beat datapath: embeds into or extracts from one carrier byte.
module lse_step #(
    parameter int LENGTH_WIDTH = lse_pkg::DEFAULT_LENGTH_WIDTH
) (
    input  lse_pkg::in_item_t         item,
    input  lse_pkg::cfg_ctrl_t        ctrl,
    input  logic [LENGTH_WIDTH-1:0]   message_length,
    input  lse_pkg::stream_state_t    cur,
    input  logic [LENGTH_WIDTH+2:0]   bits_left,
    output lse_pkg::stream_state_t    nxt,
    output logic [LENGTH_WIDTH+2:0]   bits_left_next,
    output lse_pkg::out_item_t        result
);
    import lse_pkg::*;

    localparam int LEFT_WIDTH = LENGTH_WIDTH + 3;
    localparam int CMP_WIDTH  = (LENGTH_WIDTH > COUNT_WIDTH) ? LENGTH_WIDTH : COUNT_WIDTH;

    logic [FILL_WIDTH-1:0] n;
    logic [BYTE_BITS-1:0]  mask8;
    logic                  msg_done;
    logic                  short_tail;
    logic [FILL_WIDTH-1:0] take;
    logic                  have_bits;
    logic [FILL_WIDTH-1:0] emb_fill;
    logic [BUF_WIDTH-1:0]  chunk_raw;
    logic [BUF_WIDTH-1:0]  chunk;
    logic                  emb_pad;
    logic [BYTE_BITS-1:0]  emb_byte;
    logic [BUF_WIDTH-1:0]  ext_buf;
    logic [FILL_WIDTH-1:0] ext_sum;
    logic                  ext_full;
    logic [FILL_WIDTH-1:0] ext_fill;
    logic [BYTE_BITS-1:0]  ext_byte;

    // Common terms: field size and message progress.
    assign n          = eff_n(ctrl.bits_per_byte);
    assign mask8      = BYTE_BITS'(low_mask(n));
    assign msg_done   = CMP_WIDTH'(cur.byte_counter) >= CMP_WIDTH'(message_length);
    assign short_tail = bits_left < LEFT_WIDTH'(n);
    assign take       = short_tail ? bits_left[FILL_WIDTH-1:0] : n;

    // Embed: take the oldest bits from the buffer, zero filling what is missing.
    assign have_bits = cur.buffered_bits >= take;
    assign emb_fill  = have_bits ? FILL_WIDTH'(cur.buffered_bits - take) : '0;
    assign chunk_raw = have_bits
        ? ((cur.bit_buffer >> FILL_WIDTH'(cur.buffered_bits - take)) & low_mask(take))
        : ((cur.bit_buffer & low_mask(cur.buffered_bits))
              << FILL_WIDTH'(take - cur.buffered_bits));
    assign chunk     = short_tail ? (chunk_raw << FILL_WIDTH'(n - take)) : chunk_raw;
    assign emb_pad   = !have_bits || short_tail;
    assign emb_byte  = (item.data_byte & ~mask8) | chunk[BYTE_BITS-1:0];

    // Extract: append the low bits and peel off a byte once eight are held.
    assign ext_buf  = (cur.bit_buffer << n) | BUF_WIDTH'(item.data_byte & mask8);
    assign ext_sum  = FILL_WIDTH'(cur.buffered_bits + n);
    assign ext_full = ext_sum >= FILL_WIDTH'(BYTE_BITS);
    assign ext_fill = FILL_WIDTH'(ext_sum - FILL_WIDTH'(BYTE_BITS));
    assign ext_byte = BYTE_BITS'(ext_buf >> ext_fill);

    // Select the next state and the result by opcode and mode.
    always_comb
    begin
        nxt            = cur;
        bits_left_next = bits_left;
        result         = '0;
        result.status  = ST_OK;
        case (item.opcode)
            OP_CLEAR:
            begin
                nxt            = '0;
                bits_left_next = {message_length, 3'b000};
            end
            OP_MESSAGE:
            begin
                if (ctrl.extract_mode)
                begin
                    result.status = ST_IGNORED;
                end
                else if (msg_done || cur.buffered_bits > FILL_WIDTH'(BYTE_BITS - 1))
                begin
                    result.status = ST_REFUSED;
                end
                else
                begin
                    nxt.bit_buffer    = BUF_WIDTH'({cur.bit_buffer, item.data_byte});
                    nxt.buffered_bits = FILL_WIDTH'(cur.buffered_bits + FILL_WIDTH'(BYTE_BITS));
                    nxt.byte_counter  = COUNT_WIDTH'(cur.byte_counter + COUNT_WIDTH'(1));
                end
            end
            OP_CARRIER:
            begin
                if (!ctrl.extract_mode)
                begin
                    result.out_valid = 1'b1;
                    if (bits_left == '0)
                    begin
                        result.out_byte = item.data_byte;
                        result.status   = ST_DONE;
                    end
                    else
                    begin
                        result.out_byte   = emb_byte;
                        result.status     = emb_pad ? ST_PADDED : ST_OK;
                        nxt.buffered_bits = emb_fill;
                        nxt.bit_buffer    = cur.bit_buffer & low_mask(emb_fill);
                        bits_left_next    = LEFT_WIDTH'(bits_left - LEFT_WIDTH'(take));
                    end
                end
                else if (msg_done)
                begin
                    result.status = ST_DONE;
                end
                else if (ext_full)
                begin
                    result.out_byte   = ext_byte;
                    result.out_valid  = 1'b1;
                    nxt.buffered_bits = ext_fill;
                    nxt.bit_buffer    = ext_buf & low_mask(ext_fill);
                    nxt.byte_counter  = COUNT_WIDTH'(cur.byte_counter + COUNT_WIDTH'(1));
                end
                else
                begin
                    nxt.buffered_bits = ext_sum;
                    nxt.bit_buffer    = ext_buf;
                end
            end
            default:
            begin
                result.status = ST_IGNORED;
            end
        endcase
    end

endmodule

// ----- verif/lsb_stego_embed_extract_top_tb.sv -----
// Self-checking testbench for the LSB embed/extract block with a built-in stream predictor.
module lsb_stego_embed_extract_top_tb;
    import lse_pkg::*;

    localparam int LEN_W         = DEFAULT_LENGTH_WIDTH;
    localparam int RANDOM_BEATS  = 650;
    localparam int QUIET_LIMIT   = 3000;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the hidden-bit stream, predicts one result per input beat and checks results.
    class lsb_stream_tracker;
        bit [BPB_WIDTH-1:0]   bpb_reg;
        bit                   mode_reg;
        bit [LEN_W-1:0]       length_reg;
        bit [BUF_WIDTH-1:0]   pend_bits;
        bit [FILL_WIDTH-1:0]  pend_count;
        bit [COUNT_WIDTH-1:0] msg_count;
        bit [18:0]            bits_to_hide;
        out_item_t            awaited[$];
        int                   errors;

        function new();
            bpb_reg = BPB_RESET;
            mode_reg = 1'b0;
            length_reg = '0;
            errors = 0;
            restart();
        endfunction

        function int lowbits(int k);
            return (1 << k) - 1;
        endfunction

        // Zero bits per byte counts as one, anything above eight as eight.
        function int bits_used();
            if (bpb_reg == 0)
            begin
                return 1;
            end
            if (bpb_reg > BYTE_BITS)
            begin
                return BYTE_BITS;
            end
            return bpb_reg;
        endfunction

        function void restart();
            pend_bits = '0;
            pend_count = '0;
            msg_count = '0;
            bits_to_hide = 19'(length_reg) * 19'(BYTE_BITS);
        endfunction

        // Any register write also restarts the stream.
        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [LEN_W-1:0] data);
            if (idx == REG_BITS_PER_BYTE)
            begin
                bpb_reg = data[BPB_WIDTH-1:0];
            end
            else if (idx == REG_EXTRACT_MODE)
            begin
                mode_reg = data[0];
            end
            else if (idx == REG_MESSAGE_LENGTH)
            begin
                length_reg = data;
            end
            if (idx <= REG_MESSAGE_LENGTH)
            begin
                restart();
            end
        endfunction

        // Advances the stream by one input beat and returns the result it should give.
        function out_item_t step_result(in_item_t beat);
            out_item_t r;
            int n;
            int d;
            int pb;
            int fill;
            int take;
            int chunk;
            r = '0;
            n = bits_used();
            d = beat.data_byte;
            pb = pend_bits;
            fill = pend_count;
            case (beat.opcode)
                OP_CLEAR:
                begin
                    restart();
                end
                OP_MESSAGE:
                begin
                    if (mode_reg)
                    begin
                        r.status = ST_IGNORED;
                    end
                    else if (msg_count >= length_reg || pend_count > 7)
                    begin
                        r.status = ST_REFUSED;
                    end
                    else
                    begin
                        pend_bits = BUF_WIDTH'((pb << BYTE_BITS) | d);
                        pend_count = FILL_WIDTH'(fill + BYTE_BITS);
                        msg_count = msg_count + 1'b1;
                    end
                end
                OP_CARRIER:
                begin
                    if (!mode_reg)
                    begin
                        if (bits_to_hide == 0)
                        begin
                            // Message fully hidden: carrier passes through.
                            r.out_byte = beat.data_byte;
                            r.out_valid = 1'b1;
                            r.status = ST_DONE;
                        end
                        else
                        begin
                            take = (bits_to_hide < n) ? int'(bits_to_hide) : n;
                            if (fill >= take)
                            begin
                                chunk = (pb >> (fill - take)) & lowbits(take);
                                fill = fill - take;
                            end
                            else
                            begin
                                // Buffer ran dry: missing bits count as zeros.
                                chunk = (pb & lowbits(fill)) << (take - fill);
                                fill = 0;
                                r.status = ST_PADDED;
                            end
                            if (take < n)
                            begin
                                // Last partial chunk sits at the top of the n-bit field.
                                chunk = chunk << (n - take);
                                r.status = ST_PADDED;
                            end
                            pend_bits = BUF_WIDTH'(pb & lowbits(fill));
                            pend_count = FILL_WIDTH'(fill);
                            bits_to_hide = bits_to_hide - 19'(take);
                            r.out_byte = BYTE_BITS'((d & ~lowbits(n)) | chunk);
                            r.out_valid = 1'b1;
                        end
                    end
                    else if (msg_count >= length_reg)
                    begin
                        r.status = ST_DONE;
                    end
                    else
                    begin
                        // Collect the low n bits; a full byte leaves oldest bits first.
                        pb = ((pb << n) | (d & lowbits(n))) & lowbits(BUF_WIDTH);
                        fill = fill + n;
                        if (fill >= BYTE_BITS)
                        begin
                            r.out_byte = BYTE_BITS'(pb >> (fill - BYTE_BITS));
                            r.out_valid = 1'b1;
                            fill = fill - BYTE_BITS;
                            pb = pb & lowbits(fill);
                            msg_count = msg_count + 1'b1;
                        end
                        pend_bits = BUF_WIDTH'(pb);
                        pend_count = FILL_WIDTH'(fill);
                    end
                end
                default:
                begin
                    r.status = ST_IGNORED;
                end
            endcase
            return r;
        endfunction

        function void note_beat(in_item_t beat);
            awaited.push_back(step_result(beat));
        endfunction

        function void check_beat(out_item_t got);
            out_item_t exp;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("Unexpected result beat: byte %02h valid %0d status %0d",
                             got.out_byte, got.out_valid, got.status);
                end
            end
            else
            begin
                exp = awaited.pop_front();
                if (got.out_byte !== exp.out_byte || got.out_valid !== exp.out_valid ||
                    got.status !== exp.status)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $write("Result mismatch: expected byte %02h valid %0d status %0d, ",
                               exp.out_byte, exp.out_valid, exp.status);
                        $display("got byte %02h valid %0d status %0d",
                                 got.out_byte, got.out_valid, got.status);
                    end
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    in_item_t                   in_item;
    logic                       out_valid;
    logic                       out_ready;
    out_item_t                  out_item;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [LEN_W-1:0]           cfg_data;

    lsb_stream_tracker tracker;
    bit                long_hold_due = 1'b0;
    bit                steady = 1'b0;
    int                burst_left = 0;
    int                quiet_cycles = 0;

    lsb_stego_embed_extract_top #(
        .LENGTH_WIDTH(LEN_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one beat, with a random gap between bursts, and waits for it to be taken.
    task automatic offer(input logic [OPCODE_WIDTH-1:0] op, input logic [BYTE_BITS-1:0] data);
        in_item_t beat;
        int gap;
        beat.opcode = op;
        beat.data_byte = data;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_item <= beat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_beat(beat);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [LEN_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // Writes all three registers while the block is idle.
    task automatic configure(input logic [LEN_W-1:0] bpb, input logic [LEN_W-1:0] mode,
                             input logic [LEN_W-1:0] len);
        settle();
        write_cfg(REG_MESSAGE_LENGTH, len);
        write_cfg(REG_BITS_PER_BYTE, bpb);
        write_cfg(REG_EXTRACT_MODE, mode);
        cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    // Main stimulus: reset, directed cases, then random phases.
    initial
    begin : stimulus
        int sent;
        int phase;
        int beats;
        int pick;
        int bpb;
        int mode;
        logic [LEN_W-1:0] len;
        logic [OPCODE_WIDTH-1:0] op;
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty message, so refusal, pass-through, reserved opcode, clear.
        offer(OP_MESSAGE, 8'h5A);
        offer(OP_CARRIER, 8'hFF);
        offer(OP_RESERVED, 8'h00);
        offer(OP_CLEAR, 8'hFF);

        // Three bits per carrier, two message bytes: full-buffer refusal, final
        // padded chunk, pass-through after the message, refusal past the length.
        configure(16'd3, 16'd0, 16'd2);
        offer(OP_MESSAGE, 8'hA5);
        offer(OP_MESSAGE, 8'h3C);
        offer(OP_CARRIER, 8'hFF);
        offer(OP_CARRIER, 8'h00);
        offer(OP_MESSAGE, 8'h3C);
        offer(OP_CARRIER, 8'hFF);
        offer(OP_CARRIER, 8'h00);
        offer(OP_CARRIER, 8'hAA);
        offer(OP_CARRIER, 8'h55);
        offer(OP_CARRIER, 8'h81);
        offer(OP_MESSAGE, 8'h11);

        // Oversized bits per byte acts as eight; carrier with an empty buffer is zero padded.
        configure(16'hFFFF, 16'd0, 16'd1);
        offer(OP_CARRIER, 8'h00);
        offer(OP_CARRIER, 8'h7E);

        // Extraction at eight bits, then done, then a message byte that is ignored.
        configure(16'd8, 16'hFFFF, 16'd2);
        offer(OP_CARRIER, 8'h00);
        offer(OP_CARRIER, 8'hFF);
        offer(OP_CARRIER, 8'h12);
        offer(OP_MESSAGE, 8'h34);

        // Random phases, each with its own settings.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_BEATS)
        begin
            case (phase % 5)
                0: bpb = 1;
                1: bpb = 8;
                2: bpb = 0;
                3: bpb = 15;
                default: bpb = $urandom_range(0, 15);
            endcase
            mode = (phase < 10) ? (phase / 5) % 2 : $urandom_range(0, 1);
            pick = $urandom_range(0, 7);
            if (pick == 0)
            begin
                len = '1;
            end
            else if (pick == 1)
            begin
                len = LEN_W'($urandom);
            end
            else
            begin
                len = LEN_W'($urandom_range(0, 12));
            end
            configure(LEN_W'(($urandom & 32'hFFF0) | bpb),
                      LEN_W'(($urandom & 32'hFFFE) | mode), len);
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 3)
            begin
                // Keep offering while the receiver holds off so the block backs up.
                steady = 1'b1;
                long_hold_due = 1'b1;
            end
            beats = $urandom_range(25, 60);
            repeat (beats)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    op = OPCODE_WIDTH'($urandom_range(0, 3));
                end
                else if (!tracker.mode_reg && tracker.msg_count < tracker.length_reg &&
                         tracker.pend_count <= 7 && $urandom_range(0, 3) != 0)
                begin
                    op = OP_MESSAGE;
                end
                else
                begin
                    op = OP_CARRIER;
                end
                offer(op, BYTE_BITS'($urandom_range(0, 255)));
                sent++;
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: stall styles change now and then, plus one long hold-off on request.
    initial
    begin : result_sink
        int style;
        int left;
        int hold;
        out_ready = 1'b0;
        style = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_due)
            begin
                out_ready <= 1'b0;
                for (hold = 1; hold < LONG_HOLD; hold++) @(posedge clk);
                long_hold_due = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    style = $urandom_range(0, 3);
                    left = $urandom_range(30, 200);
                end
                left--;
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Check every result beat as it is taken.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            tracker.check_beat(out_item);
        end
    end

    // Count cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: give up when nothing has moved for too long.
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lse_pkg.sv
sv/lse_cfg.sv
sv/lse_step.sv
sv/lsb_stego_embed_extract_top.sv
verif/lsb_stego_embed_extract_top_tb.sv
